[sv/gsqr_pkg.sv]
package gsqr_pkg;

  localparam int unsigned DefRows = 3;
  localparam int unsigned DefCols = 3;
  localparam int unsigned DataW = 32;
  localparam int unsigned ThrW = 16;
  localparam int unsigned ColW = 2;
  localparam logic [DataW-1:0] OneQ16 = 32'h0001_0000;
  localparam logic [1:0] RegThreshold = 2'd0;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_DOT,
    OP_SUB,
    OP_SQR,
    OP_SQRT,
    OP_DIV,
    OP_FIN
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] col;
    logic [1:0] idx;
    logic       step_start;
  } gsqr_cmd_t;

  typedef struct packed {
    logic step_done;
    logic degen;
  } gsqr_stat_t;

  function automatic logic signed [DataW-1:0] sat32(input logic signed [67:0] x);
    if (x > 68'sh0_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (x < -68'sh0_8000_0000) begin
      return -32'sh8000_0000;
    end
    return x[DataW-1:0];
  endfunction

  function automatic logic signed [DataW:0] rnd30(input logic signed [63:0] p);
    logic [63:0] m;
    logic [63:0] s;
    m = p[63] ? 64'(-p) : 64'(p);
    s = (m + 64'(1 << 29)) >> 30;
    return p[63] ? -$signed(s[DataW:0]) : $signed(s[DataW:0]);
  endfunction

endpackage

[sv/gsqr_ctrl.sv]
module gsqr_ctrl import gsqr_pkg::*; #(
  parameter int unsigned Rows = DefRows,
  parameter int unsigned Cols = DefCols
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_first_column,
  output logic       out_valid,
  input  logic       out_stall,
  output gsqr_cmd_t  cmd,
  input  gsqr_stat_t stat
);

  typedef enum logic [2:0] {S_IDLE, S_DOT, S_SUB, S_SQR, S_SQRT, S_DIV, S_OUT} st_t;

  st_t        st_r;
  logic [1:0] next_r;
  logic [1:0] col_r;
  logic [1:0] idx_r;
  logic       go_r;
  logic       out_valid_r;
  logic [1:0] col_nxt;

  assign in_stall  = (st_r != S_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;

  always_comb begin
    col_nxt = in_first_column ? 2'd0 : next_r;
    if (32'(col_nxt) >= Cols) begin
      col_nxt = 2'd0;
    end
  end

  always_comb begin
    cmd.col = col_r;
    cmd.idx = idx_r;
    cmd.step_start = go_r;
    cmd.op = OP_IDLE;
    unique case (st_r)
      S_IDLE: cmd.op = (in_valid && !in_stall) ? OP_LOAD : OP_IDLE;
      S_DOT:  cmd.op = OP_DOT;
      S_SUB:  cmd.op = OP_SUB;
      S_SQR:  cmd.op = OP_SQR;
      S_SQRT: cmd.op = OP_SQRT;
      S_DIV:  cmd.op = OP_DIV;
      S_OUT:  cmd.op = OP_FIN;
      default: cmd.op = OP_IDLE;
    endcase
    if (st_r == S_IDLE) begin
      cmd.col = col_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      next_r <= 2'd0;
      col_r <= 2'd0;
      idx_r <= 2'd0;
      go_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      go_r <= 1'b0;
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (st_r)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            col_r <= col_nxt;
            idx_r <= 2'd0;
            next_r <= (32'(col_nxt) + 1 >= Cols) ? 2'd0 : col_nxt + 2'd1;
            go_r <= 1'b1;
            st_r <= (col_nxt == 2'd0) ? S_SQR : S_DOT;
          end
        end
        S_DOT: begin
          if (stat.step_done) begin
            st_r <= S_SUB;
            go_r <= 1'b1;
          end
        end
        S_SUB: begin
          if (stat.step_done) begin
            go_r <= 1'b1;
            if (idx_r + 2'd1 == col_r) begin
              st_r <= S_SQR;
            end else begin
              idx_r <= idx_r + 2'd1;
              st_r <= S_DOT;
            end
          end
        end
        S_SQR: begin
          if (stat.step_done) begin
            st_r <= S_SQRT;
            go_r <= 1'b1;
          end
        end
        S_SQRT: begin
          if (stat.step_done) begin
            go_r <= 1'b1;
            idx_r <= 2'd0;
            st_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (stat.degen) begin
            st_r <= S_OUT;
          end else if (stat.step_done) begin
            if (32'(idx_r) + 1 >= Rows) begin
              st_r <= S_OUT;
            end else begin
              idx_r <= idx_r + 2'd1;
              go_r <= 1'b1;
            end
          end
        end
        S_OUT: begin
          out_valid_r <= 1'b1;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule

[sv/gsqr_dp.sv]
module gsqr_dp import gsqr_pkg::*; #(
  parameter int unsigned Rows = DefRows
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  gsqr_cmd_t               cmd,
  output gsqr_stat_t              stat,
  input  logic [ThrW-1:0]         thr,
  input  logic signed [DataW-1:0] in_a_row0,
  input  logic signed [DataW-1:0] in_a_row1,
  input  logic signed [DataW-1:0] in_a_row2,
  output logic signed [DataW-1:0] out_q_row0,
  output logic signed [DataW-1:0] out_q_row1,
  output logic signed [DataW-1:0] out_q_row2,
  output logic signed [DataW-1:0] out_r_row0,
  output logic signed [DataW-1:0] out_r_row1,
  output logic signed [DataW-1:0] out_r_row2,
  output logic [ColW-1:0]         out_column_index,
  output logic                    out_was_degenerate
);

  logic signed [DataW-1:0] qmem [3][3];
  logic signed [DataW-1:0] v_r [3];
  logic signed [DataW-1:0] r_r [3];
  logic signed [DataW-1:0] q_r [3];
  logic signed [DataW-1:0] o_q_r [3];
  logic signed [DataW-1:0] o_r_r [3];
  logic [ColW-1:0]         o_col_r;
  logic                    o_deg_r;
  logic [1:0]              k_r;
  logic [2:0]              ph_r;
  logic                    busy_r;
  logic signed [63:0]      prod_r;
  logic signed [35:0]      acc_r;
  logic [65:0]             vv_r;
  logic [65:0]             rem_r;
  logic [32:0]             root_r;
  logic [5:0]              cnt_r;
  logic                    degen_r;
  logic [63:0]             num_r;
  logic [63:0]             quo_r;
  logic                    neg_r;
  logic                    done_r;
  logic signed [DataW-1:0] ma;
  logic signed [DataW-1:0] mb;
  logic signed [63:0]      prod;
  logic [65:0]             trial;
  logic [32:0]             root_nxt;
  logic [63:0]             dtry;
  logic                    last_k;

  assign last_k = 32'(k_r) + 1 >= Rows;
  assign stat.step_done = done_r;
  assign stat.degen = degen_r && (cmd.op == OP_DIV);

  always_comb begin
    ma = 32'sd0;
    mb = 32'sd0;
    unique case (cmd.op)
      OP_DOT: begin
        ma = qmem[cmd.idx][k_r];
        mb = v_r[k_r];
      end
      OP_SUB: begin
        ma = qmem[cmd.idx][k_r];
        mb = r_r[cmd.idx];
      end
      OP_SQR: begin
        ma = v_r[k_r];
        mb = v_r[k_r];
      end
      default: begin
        ma = 32'sd0;
        mb = 32'sd0;
      end
    endcase
    prod = ma * mb;
    trial = {rem_r[63:0], vv_r[65:64]} - {root_r[31:0], 2'b01};
    root_nxt = {root_r[31:0], ~trial[65]};
    dtry = num_r - {root_r, 31'd0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
      busy_r <= 1'b0;
      degen_r <= 1'b0;
      k_r <= 2'd0;
      ph_r <= 3'd0;
    end else begin
      done_r <= 1'b0;
      if (cmd.op == OP_LOAD) begin
        v_r[0] <= in_a_row0;
        v_r[1] <= (Rows > 1) ? in_a_row1 : 32'sd0;
        v_r[2] <= (Rows > 2) ? in_a_row2 : 32'sd0;
        for (int i = 0; i < 3; i++) begin
          r_r[i] <= 32'sd0;
        end
      end
      if (cmd.step_start) begin
        busy_r <= 1'b1;
        k_r <= 2'd0;
        ph_r <= 3'd0;
        acc_r <= 36'sd0;
        cnt_r <= 6'd0;
        if (cmd.op == OP_SQR) begin
          vv_r <= 66'd0;
        end
        if (cmd.op == OP_SQRT) begin
          rem_r <= 66'd0;
          root_r <= 33'd0;
        end
        if (cmd.op == OP_DIV) begin
          neg_r <= v_r[cmd.idx][DataW-1];
          num_r <= 64'(v_r[cmd.idx][DataW-1] ? -33'(v_r[cmd.idx]) : 33'(v_r[cmd.idx])) << 30;
          quo_r <= 64'd0;
        end
      end else if (busy_r && !done_r) begin
        unique case (cmd.op)
          OP_DOT, OP_SUB, OP_SQR: begin
            if (ph_r == 3'd0) begin
              prod_r <= prod;
              ph_r <= 3'd1;
            end else begin
              ph_r <= 3'd0;
              if (cmd.op == OP_DOT) begin
                acc_r <= acc_r + 36'(rnd30(prod_r));
                if (last_k) begin
                  r_r[cmd.idx] <= sat32(68'(acc_r + 36'(rnd30(prod_r))));
                end
              end else if (cmd.op == OP_SUB) begin
                v_r[k_r] <= sat32(68'(v_r[k_r]) - 68'(rnd30(prod_r)));
              end else begin
                vv_r <= vv_r + 66'(unsigned'(prod_r));
              end
              if (last_k) begin
                busy_r <= 1'b0;
                done_r <= 1'b1;
              end else begin
                k_r <= k_r + 2'd1;
              end
            end
          end
          OP_SQRT: begin
            vv_r <= {vv_r[63:0], 2'b00};
            if (!trial[65]) begin
              rem_r <= trial;
            end else begin
              rem_r <= {rem_r[63:0], vv_r[65:64]};
            end
            root_r <= root_nxt;
            cnt_r <= cnt_r + 6'd1;
            if (cnt_r == 6'd32) begin
              busy_r <= 1'b0;
              done_r <= 1'b1;
              degen_r <= (root_nxt == 33'd0) || (root_nxt < 33'(thr));
            end
          end
          OP_DIV: begin
            if (cnt_r == 6'd0) begin
              num_r <= num_r + 64'(root_r[32:1]);
              cnt_r <= 6'd1;
            end else begin
              if (num_r >= {root_r, 31'd0}) begin
                num_r <= {dtry[62:0], 1'b0};
                quo_r <= {quo_r[62:0], 1'b1};
              end else begin
                num_r <= {num_r[62:0], 1'b0};
                quo_r <= {quo_r[62:0], 1'b0};
              end
              cnt_r <= cnt_r + 6'd1;
              if (cnt_r == 6'd32) begin
                busy_r <= 1'b0;
                done_r <= 1'b1;
              end
            end
          end
          default: busy_r <= 1'b0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      for (int i = 0; i < 3; i++) begin
        q_r[i] <= 32'sd0;
      end
    end
    if (cmd.op == OP_DIV && done_r) begin
      q_r[cmd.idx] <= neg_r ? -quo_r[31:0] : quo_r[31:0];
    end
    if (cmd.op == OP_FIN) begin
      for (int i = 0; i < 3; i++) begin
        o_q_r[i] <= (32'(i) < Rows && !degen_r) ? q_r[i] : 32'sd0;
        qmem[cmd.col][i] <= (32'(i) < Rows && !degen_r) ? q_r[i] : 32'sd0;
        if (2'(i) == cmd.col) begin
          o_r_r[i] <= degen_r ? OneQ16 :
            (root_r[32:31] != 2'b00 ? 32'sh7FFF_FFFF : root_r[31:0]);
        end else begin
          o_r_r[i] <= r_r[i];
        end
      end
      o_col_r <= cmd.col;
      o_deg_r <= degen_r;
    end
  end

  assign out_q_row0 = o_q_r[0];
  assign out_q_row1 = o_q_r[1];
  assign out_q_row2 = o_q_r[2];
  assign out_r_row0 = o_r_r[0];
  assign out_r_row1 = o_r_r[1];
  assign out_r_row2 = o_r_r[2];
  assign out_column_index = o_col_r;
  assign out_was_degenerate = o_deg_r;

endmodule

[sv/gram_schmidt_qr_3x3_core.sv]
// Each column is projected against every earlier column (a dot-product pass, then a
// subtraction pass). A multiply pass then sums its squared length, a bit-serial square
// root gives the length, and a divider runs once per row to normalise the column.
// A degenerate column skips the divider.
// Throughput: one column at a time; the next column is taken once the result beat leaves.
// Reset (rst_n, synchronous, active low) restarts at column zero and sets the threshold to 1.
module gram_schmidt_qr_3x3_core import gsqr_pkg::*; #(
  parameter int unsigned Rows = DefRows,
  parameter int unsigned Cols = DefCols
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [DataW-1:0] in_a_row0,
  input  logic signed [DataW-1:0] in_a_row1,
  input  logic signed [DataW-1:0] in_a_row2,
  input  logic                    in_first_column,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [DataW-1:0] out_q_row0,
  output logic signed [DataW-1:0] out_q_row1,
  output logic signed [DataW-1:0] out_q_row2,
  output logic signed [DataW-1:0] out_r_row0,
  output logic signed [DataW-1:0] out_r_row1,
  output logic signed [DataW-1:0] out_r_row2,
  output logic [ColW-1:0]         out_column_index,
  output logic                    out_was_degenerate,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [1:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic [ThrW-1:0] thr_r;
  gsqr_cmd_t       cmd;
  gsqr_stat_t      stat;

  assign pready = 1'b1;
  assign prdata = (paddr == RegThreshold) ? 32'(thr_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= 16'd1;
    end else if (psel && penable && pwrite && paddr == RegThreshold) begin
      thr_r <= pwdata[ThrW-1:0];
    end
  end

  gsqr_ctrl #(.Rows(Rows), .Cols(Cols)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_first_column,
    .out_valid, .out_stall, .cmd, .stat
  );

  gsqr_dp #(.Rows(Rows)) u_dp (
    .clk, .rst_n, .cmd, .stat, .thr(thr_r),
    .in_a_row0, .in_a_row1, .in_a_row2,
    .out_q_row0, .out_q_row1, .out_q_row2,
    .out_r_row0, .out_r_row1, .out_r_row2,
    .out_column_index, .out_was_degenerate
  );

endmodule

[test/tb_gram_schmidt_qr_3x3_core.sv]
`timescale 1ns / 100ps

module tb_gram_schmidt_qr_3x3_core;
  import gsqr_pkg::*;

  typedef struct packed {
    logic signed [DataW-1:0] q0;
    logic signed [DataW-1:0] q1;
    logic signed [DataW-1:0] q2;
    logic signed [DataW-1:0] r0;
    logic signed [DataW-1:0] r1;
    logic signed [DataW-1:0] r2;
    logic [ColW-1:0]         col;
    logic                    degen;
  } qr_beat_t;

  class qr_column_predictor;
    longint qstore[9];
    int unsigned next_col;
    longint unsigned threshold;
    qr_beat_t pending_cols[$];
    int mismatches;

    function new();
      foreach (qstore[k]) qstore[k] = 0;
      next_col = 0;
      threshold = 1;
      mismatches = 0;
    endfunction

    function longint round30(longint x);
      longint unsigned m;
      m = (x < 0) ? longint'(-x) : x;
      m = (m + (64'd1 << 29)) >> 30;
      return (x < 0) ? -longint'(m) : longint'(m);
    endfunction

    function longint sat(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
    endfunction

    function longint unsigned isqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function void note_column(logic signed [31:0] a0, logic signed [31:0] a1,
                              logic signed [31:0] a2, logic fc);
      longint v[3];
      longint r[3];
      longint q[3];
      longint dot;
      longint unsigned vv, len, m;
      int unsigned c;
      bit dg;
      qr_beat_t e;
      v[0] = a0; v[1] = a1; v[2] = a2;
      r = '{0, 0, 0};
      q = '{0, 0, 0};
      c = fc ? 0 : next_col;
      if (c >= DefCols) c = 0;
      for (int i = 0; i < c; i++) begin
        dot = 0;
        for (int k = 0; k < 3; k++) dot += round30(qstore[i*3+k] * v[k]);
        r[i] = sat(dot);
        for (int k = 0; k < 3; k++) v[k] = sat(v[k] - round30(r[i] * qstore[i*3+k]));
      end
      vv = 0;
      for (int k = 0; k < 3; k++) vv += longint'(v[k] * v[k]);
      len = isqrt(vv);
      dg = (len == 0) || (len < threshold);
      if (dg) begin
        r[c] = 65536;
      end else begin
        r[c] = (len > 64'd2147483647) ? 64'sd2147483647 : longint'(len);
        for (int k = 0; k < 3; k++) begin
          m = (v[k] < 0) ? longint'(-v[k]) : v[k];
          m = ((m << 30) + (len >> 1)) / len;
          q[k] = (v[k] < 0) ? -longint'(m) : longint'(m);
        end
      end
      for (int k = 0; k < 3; k++) qstore[c*3+k] = q[k];
      next_col = (c + 1 >= DefCols) ? 0 : c + 1;
      e.q0 = 32'(q[0]); e.q1 = 32'(q[1]); e.q2 = 32'(q[2]);
      e.r0 = 32'(r[0]); e.r1 = 32'(r[1]); e.r2 = 32'(r[2]);
      e.col = 2'(c);
      e.degen = dg;
      pending_cols.insert(pending_cols.size(), e);
    endfunction

    function void check_beat(qr_beat_t got);
      qr_beat_t e;
      if (pending_cols.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result beat %h", got);
        return;
      end
      e = pending_cols.pop_front();
      if (e.q0 !== got.q0 || e.q1 !== got.q1 || e.q2 !== got.q2 || e.r0 !== got.r0 ||
          e.r1 !== got.r1 || e.r2 !== got.r2 || e.col !== got.col ||
          e.degen !== got.degen) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Mismatch q: exp %h %h %h got %h %h %h", e.q0, e.q1, e.q2,
                   got.q0, got.q1, got.q2);
          $display("  r: exp %h %h %h got %h %h %h", e.r0, e.r1, e.r2,
                   got.r0, got.r1, got.r2);
          $display("  col/degen: exp %0d/%0d got %0d/%0d", e.col, e.degen,
                   got.col, got.degen);
        end
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_stall, in_first_column;
  logic signed [DataW-1:0] in_a_row0, in_a_row1, in_a_row2;
  logic out_valid, out_stall;
  logic signed [DataW-1:0] out_q_row0, out_q_row1, out_q_row2;
  logic signed [DataW-1:0] out_r_row0, out_r_row1, out_r_row2;
  logic [ColW-1:0] out_column_index;
  logic out_was_degenerate;
  logic psel, penable, pwrite, pready;
  logic [1:0] paddr;
  logic [31:0] pwdata, prdata;

  qr_column_predictor model = new();
  bit quiet;
  bit held_once;
  int stall_left;
  int results_seen;

  gram_schmidt_qr_3x3_core uut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      model.note_column(in_a_row0, in_a_row1, in_a_row2, in_first_column);
    if (rst_n && out_valid && !out_stall) begin
      model.check_beat({out_q_row0, out_q_row1, out_q_row2, out_r_row0, out_r_row1,
                        out_r_row2, out_column_index, out_was_degenerate});
      results_seen++;
    end
  end

  // The receiver stalls at random, and once for long so the input backs up.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!held_once && results_seen >= 40) begin
      held_once = 1;
      stall_left = 400;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 5);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic write_threshold(logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 2'(RegThreshold) << 2;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    model.threshold = value & 32'hFFFF;
  endtask

  task automatic send_column(logic [31:0] a0, logic [31:0] a1, logic [31:0] a2, logic fc);
    int gap;
    in_valid <= 1'b1;
    in_a_row0 <= a0;
    in_a_row1 <= a1;
    in_a_row2 <= a2;
    in_first_column <= fc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] rand_elem();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2, 3: return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
      4: return 32'($signed($urandom_range(0, 200)) - 100);
      default: return $urandom;
    endcase
  endfunction

  task automatic drain();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (model.pending_cols.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (200) @(posedge clk);
  endtask

  initial begin
    logic [31:0] thr_list[5];
    logic [31:0] p0, p1, p2;
    logic [31:0] c0, c1, c2;
    in_valid = 0;
    in_first_column = 0;
    in_a_row0 = 0;
    in_a_row1 = 0;
    in_a_row2 = 0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = 0;
    pwdata = 0;
    rst_n = 0;
    quiet = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    send_column(0, 0, 0, 1);
    send_column(1, 0, 0, 0);
    send_column(0, 32'hFFFF_FFFF, 0, 0);
    send_column(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1);
    send_column(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
    send_column(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0);
    send_column(32'h0001_0000, 0, 0, 1);
    send_column(0, 32'h0001_0000, 0, 0);
    send_column(0, 0, 32'h0001_0000, 0);
    send_column(32'h0002_0000, 32'h0003_0000, 32'h0001_0000, 0);
    send_column(32'h0003_0000, 32'h0001_0000, 32'h0002_0000, 1);
    send_column(32'h0003_0000, 32'h0001_0000, 32'h0002_0000, 0);
    send_column(32'hFFFD_0000, 32'hFFFF_0000, 32'hFFFE_0000, 0);
    send_column(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1);
    send_column(32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
    send_column(5, 32'hFFFF_FFFB, 3, 0);
    drain();

    thr_list = '{32'd1, 32'd0, 32'hFFFF, $urandom_range(2, 65534), 32'hFFFF_0123};
    foreach (thr_list[ph]) begin
      write_threshold(thr_list[ph]);
      for (int n = 0; n < 380; n++) begin
        if (ph == 4 && n >= 280) quiet = 1;
        if ($urandom_range(0, 9) == 0) begin
          send_column(rand_elem(), rand_elem(), rand_elem(), $urandom_range(0, 1));
        end else begin
          for (int c = 0; c < 3; c++) begin
            c0 = rand_elem(); c1 = rand_elem(); c2 = rand_elem();
            if (c > 0 && $urandom_range(0, 5) == 0) begin
              c0 = p0 + $urandom_range(0, 3);
              c1 = $urandom_range(0, 1) ? p1 : -p1;
              c2 = p2;
            end
            send_column(c0, c1, c2, c == 0);
            p0 = c0; p1 = c1; p2 = c2;
          end
          n += 2;
        end
      end
      drain();
    end

    if (model.mismatches == 0 && model.pending_cols.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
